>>> design/cir_pkg.sv
`default_nettype none

package cir_pkg;

    // Fixed field widths
    localparam int INV_W     = 32;          // inverse mass, unsigned Q16.16
    localparam int TOT_W     = INV_W + 1;   // summed inverse mass
    localparam int RATIO_W   = INV_W + 1;   // mass share, unsigned Q1.32, up to 1.0
    localparam int NORM_W    = 16;          // normal, signed Q2.14
    localparam int REST_W    = 16;          // restitution, unsigned Q1.15
    localparam int FACT_W    = REST_W + 1;  // 1.0 + restitution

    localparam int NORM_FRAC  = 14;
    localparam int REST_FRAC  = 15;
    localparam int RATIO_FRAC = 32;
    localparam int PP_CHUNK   = 16;         // delta slice width per partial product

    // One quotient bit per divider stage, the leading integer bit included
    localparam int DIV_STAGES = RATIO_W;

    localparam logic [FACT_W-1:0]  REST_ONE   = FACT_W'(32768);
    localparam logic [REST_W-1:0]  REST_RESET = REST_W'(32768);
    localparam logic [RATIO_W-1:0] RATIO_ONE  = {1'b1, {(RATIO_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OUT_SEPARATING = 2'd0,
        OUT_IMMOVABLE  = 2'd1,
        OUT_IMPULSE    = 2'd2
    } outcome_t;

endpackage

`default_nettype wire

>>> design/cir_div.sv
`default_nettype none

// Pipelined radix-2 restoring divider: quo = floor(dividend * 2^32 / divisor).
// One quotient bit per stage; the quotient is taken from the last stage register.
module cir_div (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [cir_pkg::INV_W-1:0]    dividend,
    input  wire logic [cir_pkg::TOT_W-1:0]    divisor,
    output logic      [cir_pkg::RATIO_W-1:0]  quo,
    output logic                              rem_nz
);
    import cir_pkg::*;

    logic [TOT_W-1:0]   rem_reg [DIV_STAGES];
    logic [RATIO_W-1:0] quo_reg [DIV_STAGES];
    logic [TOT_W-1:0]   dvs_reg [DIV_STAGES];

    logic [TOT_W-1:0]   rem_next [DIV_STAGES];
    logic [RATIO_W-1:0] quo_next [DIV_STAGES];

    // Leading stage: integer bit of the quotient
    always_comb
    begin
        logic [TOT_W-1:0] ext;
        ext = {1'b0, dividend};
        if (ext >= divisor)
        begin
            rem_next[0] = ext - divisor;
            quo_next[0] = RATIO_W'(1);
        end
        else
        begin
            rem_next[0] = ext;
            quo_next[0] = '0;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_step
        always_comb
        begin
            logic [TOT_W:0] r2;
            logic [TOT_W:0] d2;
            r2 = {rem_reg[k-1], 1'b0};
            d2 = {1'b0, dvs_reg[k-1]};
            if (r2 >= d2)
            begin
                rem_next[k] = TOT_W'(r2 - d2);
                quo_next[k] = {quo_reg[k-1][RATIO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = TOT_W'(r2);
                quo_next[k] = {quo_reg[k-1][RATIO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            dvs_reg[0] <= divisor;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dvs_reg[k] <= dvs_reg[k-1];
            end
        end
    end

    assign quo    = quo_reg[DIV_STAGES-1];
    assign rem_nz = (rem_reg[DIV_STAGES-1] != '0);

endmodule

`default_nettype wire

>>> design/contact_impulse_resolver.sv
// Contact impulse resolver.
// Input channel (in_valid/in_ready): one contact per word - velocities of body A and
// optional body B (Q16.16), inverse masses (unsigned Q16.16), has_body_b and the contact
// normal (Q2.14). Output channel (out_valid/out_ready): the resolved velocities of both
// bodies, saturated, plus outcome (separating, immovable, impulse applied).
// Configuration channel (cfg_valid/cfg_ready/cfg_data): restitution, unsigned Q1.15;
// always ready; write it only while no contact is in flight.
// Throughput: one contact per cycle while no result word is stalled at the output. The
// depth is set by the 33-stage radix-2 divider that forms body A's share of the impulse;
// the rest of the pipeline runs alongside it. The result word sits in the output register.
// Stall: while a result word waits on out_ready, the whole pipeline holds and in_ready
// drops in the same cycle; nothing is lost or repeated.
// Reset: clears all valid bits and loads restitution with 1.0.
`default_nettype none

module contact_impulse_resolver #(
    parameter int VELOCITY_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cir_pkg::REST_W-1:0]          cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [VELOCITY_WIDTH-1:0]    vel_a_x,
    input  wire logic signed [VELOCITY_WIDTH-1:0]    vel_a_y,
    input  wire logic signed [VELOCITY_WIDTH-1:0]    vel_a_z,
    input  wire logic signed [VELOCITY_WIDTH-1:0]    vel_b_x,
    input  wire logic signed [VELOCITY_WIDTH-1:0]    vel_b_y,
    input  wire logic signed [VELOCITY_WIDTH-1:0]    vel_b_z,
    input  wire logic [cir_pkg::INV_W-1:0]           inv_mass_a,
    input  wire logic [cir_pkg::INV_W-1:0]           inv_mass_b,
    input  wire logic                                has_body_b,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   normal_x,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   normal_y,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   normal_z,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [VELOCITY_WIDTH-1:0]         new_vel_a_x,
    output logic signed [VELOCITY_WIDTH-1:0]         new_vel_a_y,
    output logic signed [VELOCITY_WIDTH-1:0]         new_vel_a_z,
    output logic signed [VELOCITY_WIDTH-1:0]         new_vel_b_x,
    output logic signed [VELOCITY_WIDTH-1:0]         new_vel_b_y,
    output logic signed [VELOCITY_WIDTH-1:0]         new_vel_b_z,
    output cir_pkg::outcome_t                        outcome
);
    import cir_pkg::*;

    // Widths along the datapath
    localparam int W    = VELOCITY_WIDTH;
    localparam int RW   = W + 1;                 // vA - vB
    localparam int PW   = RW + NORM_W;           // one product of the dot product
    localparam int SW   = PW + 2;                // sum of three products
    localparam int EW   = W + 5;                 // separating velocity
    localparam int XW   = EW + FACT_W;           // |sep| * (1 + e)
    localparam int DW   = W + 7;                 // delta
    localparam int NCH  = (DW + PP_CHUNK - 1) / PP_CHUNK;
    localparam int DPW  = NCH * PP_CHUNK;
    localparam int PPW  = PP_CHUNK + RATIO_W;    // one partial product
    localparam int SUMW = DPW + RATIO_W;
    localparam int MW   = DW;                    // share of delta, never above delta
    localparam int NPW  = MW + 1 + NORM_W;
    localparam int DVW  = NPW - NORM_FRAC;       // velocity change per axis
    localparam int AW   = DVW + 1;
    localparam int DLY  = DIV_STAGES - 4;        // align delta with the divider output

    typedef struct packed {
        logic [2:0][W-1:0]      va;
        logic [2:0][W-1:0]      vb;
        logic [2:0][NORM_W-1:0] n;
        logic                   has_b;
    } ctx_t;

    typedef struct packed {
        ctx_t            ctx;
        logic [DW-1:0]   delta;
        outcome_t        oc;
    } dly_t;

    function automatic logic [W-1:0] sat_vel(input logic signed [AW-1:0] x);
        logic [W-1:0] r;
        if (x > AW'($signed({1'b0, {(W-1){1'b1}}})))
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        else if (x < AW'($signed({1'b1, {(W-1){1'b0}}})))
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    // Configuration
    logic [REST_W-1:0] restitution_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= REST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            restitution_reg <= cfg_data;
        end
    end

    // Global advance: the output register is free or is being drained
    logic en;
    logic v39_reg;

    assign en        = !v39_reg || out_ready;
    assign in_ready  = en;

    // Stage registers
    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                   v35_reg, v36_reg, v37_reg, v38_reg;
    logic [DLY-1:0]         dlv_reg;

    ctx_t                   ctx1_reg, ctx2_reg, ctx3_reg, ctx4_reg, ctx5_reg;
    ctx_t                   ctx35_reg, ctx36_reg, ctx37_reg, ctx38_reg;
    logic signed [RW-1:0]   r1_reg [3];
    logic [TOT_W-1:0]       tot1_reg, tot2_reg;
    logic [INV_W-1:0]       inva1_reg;
    logic signed [PW-1:0]   p2_reg [3];
    logic signed [EW-1:0]   sep3_reg;
    logic                   zt3_reg;
    logic [XW-1:0]          prod4_reg;
    outcome_t               oc4_reg, oc5_reg, oc35_reg, oc36_reg, oc37_reg, oc38_reg;
    logic [DW-1:0]          delta5_reg, delta35_reg;
    dly_t                   dl_reg [DLY];
    logic [RATIO_W-1:0]     ra35_reg, rb35_reg;
    logic [PPW-1:0]         pa36_reg [NCH];
    logic [PPW-1:0]         pb36_reg [NCH];
    logic [MW-1:0]          ma37_reg, mb37_reg;
    logic signed [DVW-1:0]  dva38_reg [3];
    logic signed [DVW-1:0]  dvb38_reg [3];
    logic [2:0][W-1:0]      va39_reg, vb39_reg;
    outcome_t               oc39_reg;

    // Next values
    ctx_t                   ctx1_next;
    logic signed [RW-1:0]   r1_next [3];
    logic [TOT_W-1:0]       tot1_next;
    logic signed [PW-1:0]   p2_next [3];
    logic signed [SW-1:0]   dot_sum;
    logic signed [EW-1:0]   sep3_next;
    logic [EW-1:0]          sep_mag;
    logic [FACT_W-1:0]      fact;
    logic [XW-1:0]          prod4_next;
    outcome_t               oc4_next;
    logic [DW-1:0]          delta5_next;
    logic [RATIO_W-1:0]     div_quo;
    logic                   div_rem_nz;
    logic [RATIO_W-1:0]     rb35_next;
    logic [DPW-1:0]         delta_pad;
    logic [PPW-1:0]         pa36_next [NCH];
    logic [PPW-1:0]         pb36_next [NCH];
    logic [SUMW-1:0]        suma, sumb;
    logic signed [NPW-1:0]  npa [3];
    logic signed [NPW-1:0]  npb [3];
    logic signed [DVW-1:0]  dva38_next [3];
    logic signed [DVW-1:0]  dvb38_next [3];
    logic [2:0][W-1:0]      va39_next, vb39_next;

    // Stage 1: drop body B when absent, form vA - vB and the summed inverse mass
    always_comb
    begin
        ctx1_next.va[0] = vel_a_x;
        ctx1_next.va[1] = vel_a_y;
        ctx1_next.va[2] = vel_a_z;
        ctx1_next.vb[0] = has_body_b ? vel_b_x : '0;
        ctx1_next.vb[1] = has_body_b ? vel_b_y : '0;
        ctx1_next.vb[2] = has_body_b ? vel_b_z : '0;
        ctx1_next.n[0]  = normal_x;
        ctx1_next.n[1]  = normal_y;
        ctx1_next.n[2]  = normal_z;
        ctx1_next.has_b = has_body_b;
        for (int i = 0; i < 3; i++)
        begin
            r1_next[i] = $signed({ctx1_next.va[i][W-1], ctx1_next.va[i]})
                       - $signed({ctx1_next.vb[i][W-1], ctx1_next.vb[i]});
        end
        tot1_next = {1'b0, inv_mass_a} + {1'b0, (has_body_b ? inv_mass_b : {INV_W{1'b0}})};
    end

    // Stage 2: one product per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p2_next[i] = r1_reg[i] * $signed(ctx1_reg.n[i]);
        end
    end

    // Stage 3: dot product, floored to Q16.16
    always_comb
    begin
        dot_sum   = SW'(p2_reg[0]) + SW'(p2_reg[1]) + SW'(p2_reg[2]);
        sep3_next = EW'(dot_sum >>> NORM_FRAC);
    end

    // Stage 4: classify and scale |sep| by (1 + e)
    always_comb
    begin
        if (sep3_reg > 0)
        begin
            oc4_next = OUT_SEPARATING;
        end
        else if (zt3_reg)
        begin
            oc4_next = OUT_IMMOVABLE;
        end
        else
        begin
            oc4_next = OUT_IMPULSE;
        end
        sep_mag    = EW'(-sep3_reg);
        fact       = REST_ONE + FACT_W'(restitution_reg);
        prod4_next = XW'(sep_mag) * XW'(fact);
    end

    // Stage 5: drop the Q1.15 fraction
    assign delta5_next = DW'(prod4_reg >> REST_FRAC);

    // Body A share of the total inverse mass
    cir_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (inva1_reg),
        .divisor  (tot1_reg),
        .quo      (div_quo),
        .rem_nz   (div_rem_nz)
    );

    // Stage 35: body B share is the complement, rounded down
    assign rb35_next = dl_reg[DLY-1].ctx.has_b
                     ? RATIO_ONE - div_quo - RATIO_W'(div_rem_nz)
                     : '0;

    // Stage 36: partial products of delta slices by the shares
    always_comb
    begin
        delta_pad = DPW'(delta35_reg);
        for (int k = 0; k < NCH; k++)
        begin
            pa36_next[k] = PPW'(delta_pad[k*PP_CHUNK +: PP_CHUNK]) * PPW'(ra35_reg);
            pb36_next[k] = PPW'(delta_pad[k*PP_CHUNK +: PP_CHUNK]) * PPW'(rb35_reg);
        end
    end

    // Stage 37: sum the partial products, keep the integer part of the Q1.32 scale
    always_comb
    begin
        suma = '0;
        sumb = '0;
        for (int k = 0; k < NCH; k++)
        begin
            suma = suma + (SUMW'(pa36_reg[k]) << (k*PP_CHUNK));
            sumb = sumb + (SUMW'(pb36_reg[k]) << (k*PP_CHUNK));
        end
    end

    // Stage 38: project the magnitudes onto the normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            npa[i]        = $signed({1'b0, ma37_reg}) * $signed(ctx37_reg.n[i]);
            npb[i]        = $signed({1'b0, mb37_reg}) * $signed(ctx37_reg.n[i]);
            dva38_next[i] = DVW'(npa[i] >>> NORM_FRAC);
            dvb38_next[i] = DVW'(npb[i] >>> NORM_FRAC);
        end
    end

    // Stage 39: apply and saturate, or pass unchanged
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (oc38_reg == OUT_IMPULSE)
            begin
                va39_next[i] = sat_vel(AW'($signed(ctx38_reg.va[i])) + AW'(dva38_reg[i]));
                vb39_next[i] = sat_vel(AW'($signed(ctx38_reg.vb[i])) - AW'(dvb38_reg[i]));
            end
            else
            begin
                va39_next[i] = ctx38_reg.va[i];
                vb39_next[i] = ctx38_reg.vb[i];
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            dlv_reg <= '0;
            v35_reg <= 1'b0;
            v36_reg <= 1'b0;
            v37_reg <= 1'b0;
            v38_reg <= 1'b0;
            v39_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            dlv_reg <= {dlv_reg[DLY-2:0], v5_reg};
            v35_reg <= dlv_reg[DLY-1];
            v36_reg <= v35_reg;
            v37_reg <= v36_reg;
            v38_reg <= v37_reg;
            v39_reg <= v38_reg;
        end
    end

    // Payload, advanced together with the valid bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx1_reg  <= ctx1_next;
            r1_reg    <= r1_next;
            tot1_reg  <= tot1_next;
            inva1_reg <= inv_mass_a;

            ctx2_reg  <= ctx1_reg;
            p2_reg    <= p2_next;
            tot2_reg  <= tot1_reg;

            ctx3_reg  <= ctx2_reg;
            sep3_reg  <= sep3_next;
            zt3_reg   <= (tot2_reg == '0);

            ctx4_reg  <= ctx3_reg;
            oc4_reg   <= oc4_next;
            prod4_reg <= prod4_next;

            ctx5_reg   <= ctx4_reg;
            oc5_reg    <= oc4_reg;
            delta5_reg <= delta5_next;

            dl_reg[0] <= '{ctx: ctx5_reg, delta: delta5_reg, oc: oc5_reg};
            for (int k = 1; k < DLY; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end

            ctx35_reg   <= dl_reg[DLY-1].ctx;
            oc35_reg    <= dl_reg[DLY-1].oc;
            delta35_reg <= dl_reg[DLY-1].delta;
            ra35_reg    <= div_quo;
            rb35_reg    <= rb35_next;

            ctx36_reg <= ctx35_reg;
            oc36_reg  <= oc35_reg;
            pa36_reg  <= pa36_next;
            pb36_reg  <= pb36_next;

            ctx37_reg <= ctx36_reg;
            oc37_reg  <= oc36_reg;
            ma37_reg  <= MW'(suma >> RATIO_FRAC);
            mb37_reg  <= MW'(sumb >> RATIO_FRAC);

            ctx38_reg <= ctx37_reg;
            oc38_reg  <= oc37_reg;
            dva38_reg <= dva38_next;
            dvb38_reg <= dvb38_next;

            va39_reg  <= va39_next;
            vb39_reg  <= vb39_next;
            oc39_reg  <= oc38_reg;
        end
    end

    assign out_valid   = v39_reg;
    assign new_vel_a_x = va39_reg[0];
    assign new_vel_a_y = va39_reg[1];
    assign new_vel_a_z = va39_reg[2];
    assign new_vel_b_x = vb39_reg[0];
    assign new_vel_b_y = vb39_reg[1];
    assign new_vel_b_z = vb39_reg[2];
    assign outcome     = oc39_reg;

endmodule

`default_nettype wire

>>> design/cir_checker.sv
`default_nettype none

module cir_checker #(
    parameter int VELOCITY_WIDTH = 32
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [VELOCITY_WIDTH-1:0]  new_vel_a_x,
    input wire logic [VELOCITY_WIDTH-1:0]  new_vel_b_x,
    input wire logic [1:0]                 outcome
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(outcome)
            && $stable(new_vel_a_x) && $stable(new_vel_b_x))
        else $error("result word changed while stalled");

    // Input is taken exactly when the output register can advance
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // A stall at the output stops the input in the same cycle
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

bind contact_impulse_resolver cir_checker #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_cir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .new_vel_a_x (new_vel_a_x),
    .new_vel_b_x (new_vel_b_x),
    .outcome     (outcome)
);

`default_nettype wire
